>>> src/msp_pkg.sv
// Package for the SysEx test-pattern checker.
// Holds packet codes, state widths, the phase type, the result struct and the counter step.
// No dependencies.
package msp_pkg;

    localparam int CNT_W               = 7;
    localparam int TOTAL_W             = 8;
    localparam int DEF_COUNTER_PERIOD  = 127;

    localparam logic [7:0] CODE_START  = 8'h04;
    localparam logic [7:0] CODE_END    = 8'h05;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    typedef enum logic [1:0] {
        PHASE_START = 2'd0,
        PHASE_CONT  = 2'd1,
        PHASE_END   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [3:0] mismatch_mask;
        logic       packet_ok;
        phase_t     phase;
        logic       pattern_done;
    } result_t;

    // Advance the pattern counter, wrapping to zero when it would reach the period.
    function automatic logic [CNT_W-1:0] next_count(
        input logic [CNT_W-1:0] c,
        input logic [CNT_W:0]   period
    );
        logic [CNT_W:0] inc;
        inc = {1'b0, c} + {{CNT_W{1'b0}}, 1'b1};
        return (inc >= period) ? '0 : inc[CNT_W-1:0];
    endfunction

endpackage

>>> src/msp_check.sv
// Per-packet compare logic of the SysEx test-pattern checker.
// Combinational: result and next state from one packet and the current state.
// Depends on msp_pkg.
module msp_check
    import msp_pkg::*;
#(
    parameter int COUNTER_PERIOD = DEF_COUNTER_PERIOD
)
(
    input  logic [7:0]         cable_code_byte,
    input  logic [7:0]         data_byte_a,
    input  logic [7:0]         data_byte_b,
    input  logic [7:0]         data_byte_c,
    input  logic [CNT_W-1:0]   counter,
    input  logic [TOTAL_W-1:0] total,
    output result_t            result,
    output logic [CNT_W-1:0]   counter_next,
    output logic [TOTAL_W-1:0] total_next
);

    localparam logic [CNT_W:0]   PERIOD = (CNT_W+1)'(COUNTER_PERIOD);
    localparam logic [TOTAL_W-1:0] LIMIT = TOTAL_W'(2 * COUNTER_PERIOD - 1);
    localparam logic [TOTAL_W-1:0] STEP  = TOTAL_W'(3);

    logic [CNT_W-1:0] c1;
    logic [CNT_W-1:0] c2;
    logic [CNT_W-1:0] c3;
    logic             below_limit;
    logic [3:0]       mask;

    // Three successive counter values per packet
    assign c1 = next_count(counter, PERIOD);
    assign c2 = next_count(c1, PERIOD);
    assign c3 = next_count(c2, PERIOD);

    assign below_limit = (total < LIMIT);

    always_comb
    begin
        mask               = '0;
        result.phase       = PHASE_END;
        result.pattern_done = 1'b0;
        counter_next       = '0;
        total_next         = '0;

        mask[0] = below_limit ? (cable_code_byte != CODE_START)
                              : (cable_code_byte != CODE_END);

        if (total == '0)
        begin
            result.phase = PHASE_START;
            mask[1]      = (data_byte_a != SYSEX_START);
            mask[2]      = (data_byte_b != {1'b0, counter});
            mask[3]      = (data_byte_c != {1'b0, c1});
            counter_next = c2;
            total_next   = STEP;
        end
        else if (below_limit)
        begin
            result.phase = PHASE_CONT;
            mask[1]      = (data_byte_a != {1'b0, counter});
            mask[2]      = (data_byte_b != {1'b0, c1});
            mask[3]      = (data_byte_c != {1'b0, c2});
            counter_next = c3;
            total_next   = total + STEP;
        end
        else
        begin
            // End packet: only the code and F7 are checked, state returns to zero
            result.phase        = PHASE_END;
            mask[1]             = (data_byte_a != SYSEX_END);
            result.pattern_done = 1'b1;
        end

        result.mismatch_mask = mask;
        result.packet_ok     = (mask == 4'b0000);
    end

endmodule

>>> src/midi_sysex_pattern_checker.sv
// Top level of the SysEx test-pattern checker for 4-byte USB-MIDI event packets.
// Instantiates msp_check; depends on msp_pkg.
//
// Usage:
//   s_axis carries one event packet per item: tdata holds the four packet
//   bytes, tlast marks the last packet of a transfer buffer.
//   m_axis carries one result per packet: tdata holds the mismatch mask and
//   the ok flag, tuser the phase and the pattern-done flag, tlast echoes the
//   buffer end of the same packet.
//   The result is registered: a packet accepted at one edge shows its result on
//   m_axis from that edge on. Throughput is one packet per cycle while m_axis
//   does not stall; the per-packet compare and three counter steps sit between
//   the state registers and the result register.
//   s_axis_tready is high while the result register is empty or being taken,
//   so a stall on m_axis holds the result and stops input after one item.
//   Reset clears the expected counter and the byte total (a start packet is
//   due next) and empties the result register.
//   A mismatch is flagged and the pattern still advances as if it matched.
module midi_sysex_pattern_checker
    import msp_pkg::*;
#(
    parameter int COUNTER_PERIOD = DEF_COUNTER_PERIOD
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] cable_code_byte, [15:8] data_byte_a, [23:16] data_byte_b, [31:24] data_byte_c
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] mismatch_mask, [4] packet_ok, [7:5] zero
    output logic [7:0]  m_axis_tdata,
    // [1:0] phase, [2] pattern_done
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    result_t            result_reg;
    result_t            result_next;
    logic               last_reg;
    logic               valid_reg;
    logic               accept;

    msp_check #(
        .COUNTER_PERIOD (COUNTER_PERIOD)
    ) u_check (
        .cable_code_byte (s_axis_tdata[7:0]),
        .data_byte_a     (s_axis_tdata[15:8]),
        .data_byte_b     (s_axis_tdata[23:16]),
        .data_byte_c     (s_axis_tdata[31:24]),
        .counter         (cnt_reg),
        .total           (total_reg),
        .result          (result_next),
        .counter_next    (cnt_next),
        .total_next      (total_next)
    );

    assign s_axis_tready = !valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg   <= cnt_next;
                total_reg <= total_next;
                valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
            last_reg   <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {3'b000, result_reg.packet_ok, result_reg.mismatch_mask};
    assign m_axis_tuser  = {result_reg.pattern_done, result_reg.phase};
    assign m_axis_tlast  = last_reg;

endmodule

>>> src/msp_checker.sv
// Port-level assertions for the SysEx test-pattern checker, bound to the top level.
// Depends on msp_pkg and midi_sysex_pattern_checker.
module msp_checker
    import msp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result holds
    property p_stall_hold;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("result changed under stall");

    property p_ok_flag;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4] == (m_axis_tdata[3:0] == 4'b0000));
    endproperty
    a_ok_flag: assert property (p_ok_flag) else $error("packet_ok disagrees with mask");

    property p_done_on_end;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser[2] == (m_axis_tuser[1:0] == PHASE_END));
    endproperty
    a_done_on_end: assert property (p_done_on_end) else $error("pattern_done off end phase");

    // End packets leave their last two bytes unchecked
    property p_end_mask;
        @(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == PHASE_END) |-> (m_axis_tdata[3:2] == 2'b00);
    endproperty
    a_end_mask: assert property (p_end_mask) else $error("end packet flags unchecked bytes");

endmodule

bind midi_sysex_pattern_checker msp_checker u_msp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
